// ----- rtl/core/spd_pkg.sv -----
package spd_pkg;

  localparam int unsigned FRAME_LEN  = 15;
  localparam int unsigned COUNT_SAT  = 16;
  localparam int unsigned POS_CHECK  = 13;
  localparam int unsigned POS_END    = 14;
  localparam int unsigned COUNT_W    = 5;

  localparam logic [7:0] START_BYTE  = 8'h00;
  localparam logic [7:0] LEN_BYTE    = 8'h0F;
  localparam logic [7:0] END_BYTE    = 8'hFF;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_COUNT = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_line;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  node_id;
    logic [31:0] timestamp;
    logic [31:0] average_bits;
    logic [15:0] aqi_value;
  } out_word_t;

endpackage

// ----- rtl/core/sensor_packet_deframer_top.sv -----
// sensor frame deframer
// in_word carries one byte of a line plus an end-of-line flag; a line should
// be a 15-byte frame: 0x00, 0x0F, node id, 4-byte timestamp, 4-byte average,
// 2-byte aqi, checksum byte, 0xFF. out_word gives one result per line end:
// status (ok, wrong byte count, bad header/checksum/end byte) and the fields,
// which are zero unless the status is ok.
// throughput: one byte per cycle while in_ready is high, set by the count
// and 8-bit sum update on the line state registers.
// the result for a line appears in the output register in the cycle after
// its last byte is accepted.
// when the receiver stalls, bytes that do not end a line are still taken;
// a line-ending byte waits until the output register is free or is being
// emptied in the same cycle.
// reset (rst_n low, synchronous) clears the line state and empties the
// output register.
module sensor_packet_deframer_top
  import spd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic               good_r, good_nxt;
  logic [7:0]         id_r, id_nxt;
  logic [31:0]        time_r, time_nxt;
  logic [31:0]        avg_r, avg_nxt;
  logic [15:0]        aqi_r, aqi_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic               accept;
  logic [7:0]         b;
  logic [7:0]         check_sum;

  assign b         = in_word.data_byte;
  assign check_sum = sum_r + b;
  assign in_ready  = out_ready || !out_valid_r || !in_word.end_of_line;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // per-byte line state update
  always_comb begin
    sum_nxt  = sum_r;
    good_nxt = good_r;
    id_nxt   = id_r;
    time_nxt = time_r;
    avg_nxt  = avg_r;
    aqi_nxt  = aqi_r;
    if (count_r <= COUNT_W'(POS_CHECK - 1)) begin
      sum_nxt = check_sum;
    end
    case (count_r) inside
      5'd0: begin
        if (b != START_BYTE) good_nxt = 1'b0;
      end
      5'd1: begin
        if (b != LEN_BYTE) good_nxt = 1'b0;
      end
      5'd2: begin
        id_nxt = b;
      end
      [5'd3:5'd6]: begin
        time_nxt = {time_r[23:0], b};
      end
      [5'd7:5'd10]: begin
        avg_nxt = {avg_r[23:0], b};
      end
      [5'd11:5'd12]: begin
        aqi_nxt = {aqi_r[7:0], b};
      end
      COUNT_W'(POS_CHECK): begin
        if (check_sum != 8'd0) good_nxt = 1'b0;
      end
      COUNT_W'(POS_END): begin
        if (b != END_BYTE) good_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    count_nxt = (count_r < COUNT_W'(COUNT_SAT)) ? count_r + 1'b1 : COUNT_W'(COUNT_SAT);
  end

  // result for a line-ending byte
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    if (accept && in_word.end_of_line) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '0;
      if (count_nxt != COUNT_W'(FRAME_LEN)) begin
        out_word_nxt.status = ST_COUNT;
      end else if (!good_nxt) begin
        out_word_nxt.status = ST_BAD;
      end else begin
        out_word_nxt.status       = ST_OK;
        out_word_nxt.node_id      = id_nxt;
        out_word_nxt.timestamp    = time_nxt;
        out_word_nxt.average_bits = avg_nxt;
        out_word_nxt.aqi_value    = aqi_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sum_r       <= '0;
      good_r      <= 1'b1;
      id_r        <= '0;
      time_r      <= '0;
      avg_r       <= '0;
      aqi_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        if (in_word.end_of_line) begin
          count_r <= '0;
          sum_r   <= '0;
          good_r  <= 1'b1;
          id_r    <= '0;
          time_r  <= '0;
          avg_r   <= '0;
          aqi_r   <= '0;
        end else begin
          count_r <= count_nxt;
          sum_r   <= sum_nxt;
          good_r  <= good_nxt;
          id_r    <= id_nxt;
          time_r  <= time_nxt;
          avg_r   <= avg_nxt;
          aqi_r   <= aqi_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

endmodule
